// File: hw/rtl/pnsw_pkg.sv
// ---------------------------------------------------------------------------
// pnsw_pkg: shared types and constants for the packed nibble span writer
// Command codes, register indexes and the control/status bundles that join
// the controller and the datapath.
// ---------------------------------------------------------------------------
package pnsw_pkg;

  localparam int unsigned KindW   = 3;
  localparam int unsigned PosXW   = 10;
  localparam int unsigned PosYW   = 9;
  localparam int unsigned ColorW  = 4;
  localparam int unsigned SpanW   = 11;
  localparam int unsigned PageW   = 8;
  localparam int unsigned OffsW   = 13;
  localparam int unsigned LenW    = 14;
  localparam int unsigned DataW   = 8;
  localparam int unsigned NibW    = 2;
  localparam int unsigned CursorW = 16;
  localparam int unsigned RegIdxW = 1;

  typedef enum logic [KindW-1:0] {
    KIND_POSITION = 3'd0,
    KIND_COLOR    = 3'd1,
    KIND_SPAN     = 3'd2,
    KIND_PIXEL    = 3'd3,
    KIND_INC_X    = 3'd4,
    KIND_DEC_X    = 3'd5,
    KIND_INC_Y    = 3'd6,
    KIND_DEC_Y    = 3'd7
  } kind_e;

  localparam logic [RegIdxW-1:0] REG_BYTES_PER_ROW = 1'b0;
  localparam logic [RegIdxW-1:0] REG_BASE_PAGE     = 1'b1;

  localparam logic [DataW-1:0] BYTES_PER_ROW_RST = 8'd160;

  localparam logic [NibW-1:0] NIB_LOW  = 2'd1;
  localparam logic [NibW-1:0] NIB_HIGH = 2'd2;
  localparam logic [NibW-1:0] NIB_BYTE = 2'd3;

  // run counter value of the fourth run, the last one a command may deliver
  localparam logic [1:0] LAST_RUN_IDX = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;  // take the input beat
    logic emit;  // produce one write run into the output register
  } cmd_t;

  typedef struct packed {
    logic item_emits;  // accepted command produces write runs
    logic out_free;    // output register can take a run this cycle
    logic run_last;    // run being produced ends the command
  } sts_t;

endpackage

// File: hw/rtl/pnsw_ctrl.sv
// ---------------------------------------------------------------------------
// pnsw_ctrl: command sequencer
// Two states: idle takes a beat, emit drives one write run per free cycle
// of the output register until the datapath flags the last run.
// ---------------------------------------------------------------------------
module pnsw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pnsw_pkg::sts_t sts_i,
  output pnsw_pkg::cmd_t cmd_o
);
  import pnsw_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
        if (in_valid_i && sts_i.item_emits) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = sts_i.out_free;
        if (sts_i.out_free && sts_i.run_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/pnsw_datapath.sv
// ---------------------------------------------------------------------------
// pnsw_datapath: pen state, run splitter and output register
// Holds cursor, row offset, color and config; cuts a span into write runs,
// one run per emit command.
// ---------------------------------------------------------------------------
module pnsw_datapath #(
  parameter int unsigned PAGE_ADDR_BITS = 13
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  pnsw_pkg::cmd_t                          cmd_i,
  output pnsw_pkg::sts_t                          sts_o,
  input  logic                                    cfg_we_i,
  input  logic [pnsw_pkg::RegIdxW-1:0]            cfg_idx_i,
  input  logic [pnsw_pkg::DataW-1:0]              cfg_wdata_i,
  input  logic [pnsw_pkg::KindW-1:0]              kind_i,
  input  logic [pnsw_pkg::PosXW-1:0]              pos_x_i,
  input  logic [pnsw_pkg::PosYW-1:0]              pos_y_i,
  input  logic [pnsw_pkg::ColorW-1:0]             pen_color_i,
  input  logic signed [pnsw_pkg::SpanW-1:0]       span_count_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [pnsw_pkg::PageW-1:0]              page_o,
  output logic [pnsw_pkg::OffsW-1:0]              page_offset_o,
  output logic [pnsw_pkg::LenW-1:0]               byte_length_o,
  output logic [pnsw_pkg::DataW-1:0]              write_data_o,
  output logic [pnsw_pkg::NibW-1:0]               nibble_enable_o,
  output logic                                    last_o
);
  import pnsw_pkg::*;

  localparam int unsigned PageSizeInt = 1 << PAGE_ADDR_BITS;
  localparam logic [PAGE_ADDR_BITS:0] PageBytes = PageSizeInt[PAGE_ADDR_BITS:0];
  localparam int unsigned HalfW = SpanW - 1;

  // config
  logic [DataW-1:0] bpr_q, base_q;

  // pen state
  logic [CursorW-1:0] cursor_q, cursor_d;
  logic [CursorW-1:0] row_q, row_d;
  logic [DataW-1:0]   color_q, color_d;

  // span progress
  logic [SpanW-1:0] count_q, count_d;
  logic [1:0]       runs_q, runs_d;
  logic             pix_q, pix_d;

  // output register
  logic              out_valid_q;
  logic [PageW-1:0]  page_q;
  logic [OffsW-1:0]  offs_q;
  logic [LenW-1:0]   len_q;
  logic [DataW-1:0]  data_q;
  logic [NibW-1:0]   nib_q;
  logic              last_q;

  kind_e kind;
  assign kind = kind_e'(kind_i);

  // ---- current run ----
  logic [CursorW-1:0]      start;
  logic [31:0]             start_w;
  logic [PAGE_ADDR_BITS:0] room;
  logic [16:0]             room17, half17;
  logic [HalfW-1:0]        half, run_len;
  logic [SpanW-1:0]        adv, rem;
  logic [NibW-1:0]         run_nib;
  logic                    run_last;
  logic [PageW-1:0]        run_page;
  logic [OffsW-1:0]        run_offs;

  assign start   = row_q + {cursor_q[CursorW-1], cursor_q[CursorW-1:1]};
  assign start_w = 32'(start);
  assign room    = PageBytes - {1'b0, start[PAGE_ADDR_BITS-1:0]};
  assign room17  = 17'(room);
  assign half    = count_q[SpanW-1:1];
  assign half17  = 17'(half);
  assign run_page = base_q + start_w[PAGE_ADDR_BITS +: PageW];
  assign run_offs = 13'(start_w & (32'(PageSizeInt) - 32'd1));

  always_comb begin
    run_len = HalfW'(1);
    adv     = SpanW'(1);
    run_nib = NIB_HIGH;
    if (pix_q) begin
      run_nib = cursor_q[0] ? NIB_LOW : NIB_HIGH;
    end else if (cursor_q[0]) begin
      run_nib = NIB_LOW;
    end else if (count_q > SpanW'(1)) begin
      run_nib = NIB_BYTE;
      run_len = (half17 > room17) ? room17[HalfW-1:0] : half;
      adv     = {run_len, 1'b0};
    end
  end

  assign rem      = count_q - adv;
  assign run_last = pix_q || (rem == '0) || (runs_q == LAST_RUN_IDX);

  // ---- state update ----
  logic [SpanW-1:0] span_u, neg_mag;
  logic [16:0]      prod;

  assign span_u  = $unsigned(span_count_i);
  assign neg_mag = ~span_u + SpanW'(1);
  assign prod    = {8'b0, pos_y_i} * {9'b0, bpr_q};

  always_comb begin
    cursor_d = cursor_q;
    row_d    = row_q;
    color_d  = color_q;
    count_d  = count_q;
    runs_d   = runs_q;
    pix_d    = pix_q;
    if (cmd_i.load) begin
      runs_d = '0;
      pix_d  = 1'b0;
      case (kind)
        KIND_POSITION: begin
          row_d    = prod[CursorW-1:0];
          cursor_d = CursorW'(pos_x_i);
        end
        KIND_COLOR: color_d = {pen_color_i, pen_color_i};
        KIND_SPAN: begin
          if (span_u[SpanW-1]) begin
            count_d  = neg_mag;
            cursor_d = cursor_q - CursorW'(neg_mag);
          end else begin
            count_d = span_u;
          end
        end
        KIND_PIXEL: pix_d = 1'b1;
        KIND_INC_X: cursor_d = cursor_q + CursorW'(1);
        KIND_DEC_X: cursor_d = cursor_q - CursorW'(1);
        KIND_INC_Y: row_d = row_q + CursorW'(bpr_q);
        KIND_DEC_Y: row_d = row_q - CursorW'(bpr_q);
        default: ;
      endcase
    end else if (cmd_i.emit && !pix_q) begin
      runs_d = runs_q + 2'd1;
      if (runs_q == LAST_RUN_IDX) begin
        // runs past the fourth are dropped; cursor skips the rest of the span
        cursor_d = cursor_q + CursorW'(count_q);
        count_d  = '0;
      end else begin
        cursor_d = cursor_q + CursorW'(adv);
        count_d  = rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpr_q    <= BYTES_PER_ROW_RST;
      base_q   <= '0;
      cursor_q <= '0;
      row_q    <= '0;
      color_q  <= '0;
      count_q  <= '0;
      runs_q   <= '0;
      pix_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BYTES_PER_ROW: bpr_q <= cfg_wdata_i;
          REG_BASE_PAGE:     base_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      cursor_q <= cursor_d;
      row_q    <= row_d;
      color_q  <= color_d;
      count_q  <= count_d;
      runs_q   <= runs_d;
      pix_q    <= pix_d;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      page_q <= run_page;
      offs_q <= run_offs;
      len_q  <= LenW'(run_len);
      data_q <= color_q;
      nib_q  <= run_nib;
      last_q <= run_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign page_o          = page_q;
  assign page_offset_o   = offs_q;
  assign byte_length_o   = len_q;
  assign write_data_o    = data_q;
  assign nibble_enable_o = nib_q;
  assign last_o          = last_q;

  assign sts_o.item_emits = (kind == KIND_PIXEL) ||
                            ((kind == KIND_SPAN) && (span_u != '0));
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign sts_o.run_last   = run_last;

  // ---- checks ----
  a_emit_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("emitted run did not reach the output register");

  a_span_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && !pix_q) |-> (count_q != '0))
    else $error("span run emitted with no pixels left");

  a_fourth_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && (runs_q == LAST_RUN_IDX)) |-> run_last)
    else $error("fourth run not marked last");

  a_load_emit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.load && cmd_i.emit))
    else $error("load and emit in the same cycle");

endmodule

// File: hw/rtl/packed_nibble_span_writer.sv
// ---------------------------------------------------------------------------
// packed_nibble_span_writer: 4bpp packed framebuffer raster engine
// Turns pen commands into paged memory-write runs with nibble enables.
// ---------------------------------------------------------------------------
// Commands arrive one beat at a time. Position, color and step commands
// produce no beats. A set-pixel command produces one write beat; a span
// produces one to four beats (odd leading nibble, whole byte runs cut at
// page edges, even trailing nibble), one per cycle in which the output
// register is free. An item that writes therefore stalls the input while
// its runs (up to 4 for a span) are produced and during any output stall;
// the sequencer handles one item at a time, and the next item may enter
// while the last run of the previous one still waits in the output
// register. If a span needs more than four runs (small pages), the fourth
// is marked last and the cursor still moves over the whole span. Even x
// addresses the high nibble, odd x the low one. Config (row stride, base
// page) must only be written while the block is idle.
// ---------------------------------------------------------------------------
module packed_nibble_span_writer #(
  parameter int unsigned PAGE_ADDR_BITS = 13
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write port
  input  logic                                cfg_we_i,
  input  logic [pnsw_pkg::RegIdxW-1:0]        cfg_idx_i,
  input  logic [pnsw_pkg::DataW-1:0]          cfg_wdata_i,
  // command channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pnsw_pkg::KindW-1:0]          kind_i,
  input  logic [pnsw_pkg::PosXW-1:0]          pos_x_i,
  input  logic [pnsw_pkg::PosYW-1:0]          pos_y_i,
  input  logic [pnsw_pkg::ColorW-1:0]         pen_color_i,
  input  logic signed [pnsw_pkg::SpanW-1:0]   span_count_i,
  // write-run channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pnsw_pkg::PageW-1:0]          page_o,
  output logic [pnsw_pkg::OffsW-1:0]          page_offset_o,
  output logic [pnsw_pkg::LenW-1:0]           byte_length_o,
  output logic [pnsw_pkg::DataW-1:0]          write_data_o,
  output logic [pnsw_pkg::NibW-1:0]           nibble_enable_o,
  output logic                                last_o
);
  import pnsw_pkg::*;

  cmd_t cmd;  // sequencer -> datapath
  sts_t sts;  // datapath -> sequencer

  // sequencer: idle/emit, owns the input stall
  pnsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: pen state, run splitting, output register
  pnsw_datapath #(
    .PAGE_ADDR_BITS (PAGE_ADDR_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .kind_i          (kind_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pen_color_i     (pen_color_i),
    .span_count_i    (span_count_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .page_o          (page_o),
    .page_offset_o   (page_offset_o),
    .byte_length_o   (byte_length_o),
    .write_data_o    (write_data_o),
    .nibble_enable_o (nibble_enable_o),
    .last_o          (last_o)
  );

endmodule
